[hw/rtl/mbrd_pkg.sv]
package mbrd_pkg;

    // Frame size limit default (length field + 6)
    localparam int MAX_FRAME_DEFAULT = 256;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_FIRST   = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND  = 2'd1;
    localparam logic [1:0] CFG_COIL_COUNT     = 2'd2;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd3;

    localparam int CFG_DATA_W = 11;

    // Result kinds
    localparam logic [1:0] KIND_COIL = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // Function codes
    localparam logic [7:0] FC_READ_COILS = 8'h01;
    localparam logic [7:0] FC_READ_REGS  = 8'h03;
    localparam logic [7:0] FC_WRITE_REG  = 8'h06;

    // Byte offsets within a frame
    localparam int OFS_FIRST_BODY = 2;
    localparam int OFS_LEN_HI     = 4;
    localparam int OFS_LEN_LO     = 5;
    localparam int OFS_FUNC       = 7;
    localparam int OFS_BYTE_COUNT = 8;
    localparam int OFS_DATA       = 9;

    // Bytes outside the length field's reach
    localparam int FRAME_OVERHEAD = 6;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_SECOND = 3'b010,
        PH_FRAME  = 3'b100
    } t_phase;

endpackage

[hw/rtl/modbus_tcp_response_decoder.sv]
// Modbus TCP response decoder.
// Input channel: one received link byte per transfer (i_rx_valid / o_rx_ready,
// payload i_rx_byte). Output channel: one decoded point per transfer
// (o_res_valid / i_res_ready) with kind, point index, signed value and a last
// flag on the final point caused by a byte.
// Configuration: i_cfg_we writes register i_cfg_idx (0 header first, 1 header
// second, 2 coil count, 3 register count) from i_cfg_data, registered on the clock edge.
// Write it only while no points are pending.
// Latency: the first point of a byte appears in the cycle after its transfer.
// Throughput: a byte yielding no point leaves the input ready; a coil byte
// yields up to 8 points, which the single result register drains at one point
// per cycle while i_res_ready holds. The next byte is taken in the cycle the
// last point of the previous one transfers.
// Reset (synchronous, active low) clears the configuration to zero, returns
// the parser to header hunting and drops any pending points.
// When the receiver stalls, the pending point holds and o_rx_ready drops.
module modbus_tcp_response_decoder #(
    parameter int MAX_FRAME = mbrd_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [mbrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [1:0]                      o_kind,
    output logic [10:0]                     o_point_index,
    output logic signed [15:0]              o_point_value,
    output logic                            o_last
);

    localparam int PW = $clog2(MAX_FRAME);
    localparam int TW = $clog2(MAX_FRAME + 1);
    localparam logic [16:0] MaxFrame17 = 17'(MAX_FRAME);

    // configuration
    logic [7:0]  r_hdr_first;
    logic [7:0]  r_hdr_second;
    logic [10:0] r_coil_count;
    logic [6:0]  r_reg_count;

    // parser state
    mbrd_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0]    r_pos, n_pos;
    logic [TW-1:0]    r_total, n_total;
    logic [7:0]       r_fc, n_fc;
    logic             r_cok, n_cok;
    logic [7:0]       r_held, n_held;
    logic [10:0]      r_next, n_next;

    // result batch for one byte
    logic        r_b_valid;
    logic [1:0]  r_b_kind;
    logic [10:0] r_b_base;
    logic [15:0] r_b_data;
    logic [3:0]  r_b_cnt;
    logic [2:0]  r_sent;

    logic        rx_fire;
    logic        res_fire;
    logic [3:0]  e_cnt;
    logic [1:0]  e_kind;
    logic [15:0] e_data;

    assign o_res_valid   = r_b_valid;
    assign o_kind        = r_b_kind;
    assign o_point_index = r_b_base + 11'(r_sent);
    assign o_point_value = (r_b_kind == mbrd_pkg::KIND_COIL)
                         ? {15'd0, r_b_data[{1'b0, r_sent}]} : r_b_data;
    assign o_last        = ({1'b0, r_sent} + 4'd1) == r_b_cnt;

    assign o_rx_ready = !r_b_valid || (i_res_ready && o_last);
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign res_fire   = r_b_valid && i_res_ready;

    always_comb begin
        logic [16:0]   tot17;
        logic [TW-1:0] cur_total;
        logic [7:0]    cur_fc;
        logic [10:0]   coil_rem;
        logic [8:0]    coil_bytes;
        logic          at_end;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_total   = r_total;
        n_fc      = r_fc;
        n_cok     = r_cok;
        n_held    = r_held;
        n_next    = r_next;
        e_cnt     = 4'd0;
        e_kind    = mbrd_pkg::KIND_COIL;
        e_data    = {8'd0, i_rx_byte};
        tot17     = {1'b0, r_held, i_rx_byte} + 17'(mbrd_pkg::FRAME_OVERHEAD);
        cur_total = r_total;
        cur_fc    = r_fc;
        coil_rem  = r_coil_count - r_next;
        coil_bytes = 9'(({1'b0, r_coil_count} + 12'd7) >> 3);
        at_end    = 1'b0;
        case (r_phase)
            mbrd_pkg::PH_HUNT: begin
                if (i_rx_byte == r_hdr_first) begin
                    n_phase = mbrd_pkg::PH_SECOND;
                end
            end
            mbrd_pkg::PH_SECOND: begin
                if (i_rx_byte == r_hdr_second) begin
                    n_phase = mbrd_pkg::PH_FRAME;
                    n_pos   = PW'(mbrd_pkg::OFS_FIRST_BODY);
                    n_total = '0;
                    n_fc    = 8'd0;
                    n_cok   = 1'b0;
                    n_held  = 8'd0;
                    n_next  = 11'd0;
                end else if (i_rx_byte != r_hdr_first) begin
                    n_phase = mbrd_pkg::PH_HUNT;
                end
            end
            mbrd_pkg::PH_FRAME: begin
                if (r_pos == PW'(mbrd_pkg::OFS_LEN_HI)) begin
                    n_held = i_rx_byte;
                end else if (r_pos == PW'(mbrd_pkg::OFS_LEN_LO)) begin
                    cur_total = tot17[TW-1:0];
                    n_total   = tot17[TW-1:0];
                end else if (r_pos == PW'(mbrd_pkg::OFS_FUNC)) begin
                    cur_fc = i_rx_byte;
                    n_fc   = i_rx_byte;
                end else if (r_pos == PW'(mbrd_pkg::OFS_BYTE_COUNT)) begin
                    if (r_fc == mbrd_pkg::FC_READ_COILS) begin
                        n_cok = ({1'b0, i_rx_byte} == coil_bytes);
                    end else if (r_fc == mbrd_pkg::FC_READ_REGS) begin
                        n_cok = (i_rx_byte[7:1] == r_reg_count);
                    end
                end else if (r_pos >= PW'(mbrd_pkg::OFS_DATA) && r_cok) begin
                    if (r_fc == mbrd_pkg::FC_READ_COILS) begin
                        if (r_next < r_coil_count) begin
                            e_cnt = (coil_rem >= 11'd8) ? 4'd8 : coil_rem[3:0];
                        end
                        e_kind = mbrd_pkg::KIND_COIL;
                        n_next = r_next + 11'(e_cnt);
                    end else if (r_fc == mbrd_pkg::FC_READ_REGS) begin
                        // odd offsets carry the high byte of a pair
                        if (r_pos[0]) begin
                            n_held = i_rx_byte;
                        end else if (r_next < {4'd0, r_reg_count}) begin
                            e_cnt  = 4'd1;
                            e_kind = mbrd_pkg::KIND_REG;
                            e_data = {r_held, i_rx_byte};
                            n_next = r_next + 11'd1;
                        end
                    end
                end
                if (r_pos == PW'(mbrd_pkg::OFS_LEN_LO) && tot17 > MaxFrame17) begin
                    // oversized: drop and hunt through the rest
                    n_phase = mbrd_pkg::PH_HUNT;
                end else begin
                    at_end = (r_pos >= PW'(mbrd_pkg::OFS_LEN_LO))
                          && ((TW'(r_pos) + TW'(1)) >= cur_total);
                    if (at_end) begin
                        if (cur_fc == mbrd_pkg::FC_WRITE_REG
                            && r_pos >= PW'(mbrd_pkg::OFS_FUNC)) begin
                            e_cnt  = 4'd1;
                            e_kind = mbrd_pkg::KIND_ACK;
                            e_data = 16'd0;
                        end
                        n_phase = mbrd_pkg::PH_HUNT;
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            default: begin
                n_phase = mbrd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= 8'd0;
            r_hdr_second <= 8'd0;
            r_coil_count <= 11'd0;
            r_reg_count  <= 7'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbrd_pkg::CFG_HEADER_FIRST:   r_hdr_first  <= i_cfg_data[7:0];
                mbrd_pkg::CFG_HEADER_SECOND:  r_hdr_second <= i_cfg_data[7:0];
                mbrd_pkg::CFG_COIL_COUNT:     r_coil_count <= i_cfg_data[10:0];
                mbrd_pkg::CFG_REGISTER_COUNT: r_reg_count  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mbrd_pkg::PH_HUNT;
            r_pos   <= '0;
            r_total <= '0;
            r_fc    <= 8'd0;
            r_cok   <= 1'b0;
            r_held  <= 8'd0;
            r_next  <= 11'd0;
        end else if (rx_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_fc    <= n_fc;
            r_cok   <= n_cok;
            r_held  <= n_held;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_sent    <= 3'd0;
        end else if (rx_fire && e_cnt != 4'd0) begin
            r_b_valid <= 1'b1;
            r_sent    <= 3'd0;
        end else if (res_fire) begin
            if (o_last) begin
                r_b_valid <= 1'b0;
            end else begin
                r_sent <= r_sent + 3'd1;
            end
        end
    end

    // batch payload: load with each new transfer that yields points
    always_ff @(posedge i_clk) begin
        if (rx_fire && e_cnt != 4'd0) begin
            r_b_kind <= e_kind;
            r_b_base <= (e_kind == mbrd_pkg::KIND_ACK) ? 11'd0 : r_next;
            r_b_data <= e_data;
            r_b_cnt  <= e_cnt;
        end
    end

    a_batch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_cnt != 4'd0 && {1'b0, r_sent} < r_b_cnt))
        else $error("pending batch count out of range");

    a_single_point_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_kind == mbrd_pkg::KIND_REG || r_b_kind == mbrd_pkg::KIND_ACK))
        |-> (r_b_cnt == 4'd1 && o_last))
        else $error("register or acknowledge batch holds more than one point");

    a_frame_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mbrd_pkg::PH_FRAME) |-> (r_pos >= PW'(mbrd_pkg::OFS_FIRST_BODY)))
        else $error("frame position below first body byte");

    a_reset_drops: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_b_valid && r_phase == mbrd_pkg::PH_HUNT))
        else $error("state not cleared by reset");

endmodule
